### hdl/phu_pkg.sv
// Shared types, character codes and keyword tables for the property header parser.
// Used by phu_parse_core, phu_result_fifo and property_header_parser_unit.
`default_nettype none

package phu_pkg;

    // Event codes of a result word.
    localparam logic [2:0] EV_RESOURCE = 3'd0;
    localparam logic [2:0] EV_STATUS   = 3'd1;
    localparam logic [2:0] EV_OPTION   = 3'd2;
    localparam logic [2:0] EV_END      = 3'd3;
    localparam logic [2:0] EV_ERROR    = 3'd4;

    // Characters with a role in the header syntax.
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam int NUM_RES = 5;
    localparam int NUM_OPT = 4;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [2:0]  resource_id;
        logic [15:0] status_value;
        logic [1:0]  option_id;
        logic [11:0] value_offset;
        logic [11:0] value_length;
        logic        run_last;
    } res_t;

    // Results produced by one byte: first holds the earlier word.
    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } push_t;

    // Strings are stored left aligned in 16 characters.
    function automatic logic [127:0] kw_str(input logic is_opt, input logic [2:0] k);
        logic [127:0] s;
        s = '0;
        if (is_opt) begin
            case (k)
                3'd0:    s = {"limit", 88'h0};
                3'd1:    s = {"offset", 80'h0};
                3'd2:    s = {"id", 112'h0};
                3'd3:    s = {"encoding", 64'h0};
                default: s = '0;
            endcase
        end else begin
            case (k)
                3'd0:    s = {"ResourceList", 32'h0};
                3'd1:    s = {"DeviceInfo", 48'h0};
                3'd2:    s = {"ChannelList", 40'h0};
                3'd3:    s = {"ChCtrlList", 48'h0};
                3'd4:    s = {"ProgramList", 40'h0};
                default: s = '0;
            endcase
        end
        return s;
    endfunction

    function automatic logic [3:0] kw_len(input logic is_opt, input logic [2:0] k);
        logic [3:0] n;
        n = 4'd0;
        if (is_opt) begin
            case (k)
                3'd0:    n = 4'd5;
                3'd1:    n = 4'd6;
                3'd2:    n = 4'd2;
                3'd3:    n = 4'd8;
                default: n = 4'd0;
            endcase
        end else begin
            case (k)
                3'd0:    n = 4'd12;
                3'd1:    n = 4'd10;
                3'd2:    n = 4'd11;
                3'd3:    n = 4'd10;
                3'd4:    n = 4'd11;
                default: n = 4'd0;
            endcase
        end
        return n;
    endfunction

    function automatic logic [7:0] str_char(input logic [127:0] s, input logic [3:0] pos);
        logic [6:0] base;
        base = 7'd120 - {pos, 3'b000};
        return s[base +: 8];
    endfunction

    function automatic logic [7:0] kw_char(input logic is_opt, input logic [2:0] k,
                                           input logic [3:0] pos);
        return str_char(kw_str(is_opt, k), pos);
    endfunction

    // First-line prefix: mode 0 is the resource line, mode 1 the status line.
    function automatic logic [7:0] prefix_char(input logic mode, input logic [3:0] pos);
        logic [127:0] s;
        s = mode ? {"{\"status\":", 48'h0} : {"{\"resource\":\"", 24'h0};
        return str_char(s, pos);
    endfunction

    function automatic logic [3:0] prefix_len(input logic mode);
        return mode ? 4'd10 : 4'd13;
    endfunction

endpackage

`default_nettype wire

### hdl/phu_channels.sv
// Handshake channels of the property header parser: header bytes in, result words out.
// Standalone; no package needed.
`default_nettype none

interface phu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_byte;
    logic       last_byte;

    modport source (output valid, header_byte, last_byte, input ready);
    modport sink (input valid, header_byte, last_byte, output ready);
endinterface

interface phu_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [2:0]  resource_id;
    logic [15:0] status_value;
    logic [1:0]  option_id;
    logic [11:0] value_offset;
    logic [11:0] value_length;
    logic        run_last;

    modport source (output valid, event_res, resource_id, status_value, option_id,
                    value_offset, value_length, run_last, input ready);
    modport sink (input valid, event_res, resource_id, status_value, option_id,
                  value_offset, value_length, run_last, output ready);
endinterface

`default_nettype wire

### hdl/property_header_parser_unit.sv
// Property header parser: streams header text bytes and reports resource, status,
// option, end-of-header and error words. Uses phu_pkg, phu_channels,
// phu_parse_core and phu_result_fifo.
//
// Usage: header bytes enter on hdr_ch with last_byte marking the final byte of a
// header. Result words leave on res_ch; run_last marks the last word a byte caused.
// cfg_wr_en writes cfg_wr_data into the header mode bit (0 resource line, 1 status
// line); write it only while the parser is idle.
// Throughput: one byte per cycle. Each byte is decoded in the cycle it is accepted
// and its words sit in a four-word result queue from the next cycle on. A byte that
// causes two words presents them on the output one after the other; hdr_ch.ready
// drops only when the queue cannot hold two more words.
// Reset clears the header mode to the resource line, empties the queue and puts
// the parser at the start of the first line. When the receiver stalls, words
// wait in the queue and input continues until it is nearly full.
// The first byte at or past MAX_HEADER_BYTES in one header gives an error word.
`default_nettype none

module property_header_parser_unit import phu_pkg::*; #(
    parameter int MAX_HEADER_BYTES = 4096
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [0:0] cfg_wr_data,
    phu_byte_if.sink        hdr_ch,
    phu_res_if.source       res_ch
);

    logic  header_mode_reg;
    logic  step;
    logic  pop;
    logic  head_valid;
    logic  room_for_two;
    push_t push;
    res_t  head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            header_mode_reg <= 1'b0;
        else if (cfg_wr_en)
            header_mode_reg <= cfg_wr_data[0];
    end

    assign hdr_ch.ready = room_for_two;
    assign step = hdr_ch.valid && room_for_two;
    assign pop = head_valid && res_ch.ready;

    phu_parse_core #(
        .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .header_mode (header_mode_reg),
        .step        (step),
        .header_byte (hdr_ch.header_byte),
        .last_byte   (hdr_ch.last_byte),
        .push        (push)
    );

    phu_result_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .pop          (pop),
        .head_valid   (head_valid),
        .head         (head),
        .room_for_two (room_for_two)
    );

    assign res_ch.valid        = head_valid;
    assign res_ch.event_res    = head.event_res;
    assign res_ch.resource_id  = head.resource_id;
    assign res_ch.status_value = head.status_value;
    assign res_ch.option_id    = head.option_id;
    assign res_ch.value_offset = head.value_offset;
    assign res_ch.value_length = head.value_length;
    assign res_ch.run_last     = head.run_last;

endmodule

`default_nettype wire

### hdl/phu_parse_core.sv
// Parser state and per-byte decode: one accepted byte updates the state and
// yields up to two result words. Depends on phu_pkg.
`default_nettype none

module phu_parse_core import phu_pkg::*; #(
    parameter int MAX_HEADER_BYTES = 4096
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       header_mode,
    input  wire logic       step,
    input  wire logic [7:0] header_byte,
    input  wire logic       last_byte,
    output push_t           push
);

    localparam int IDX_W = $clog2(MAX_HEADER_BYTES + 1);
    localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_HEADER_BYTES);

    localparam logic [3:0] PH_PREFIX = 4'd0;
    localparam logic [3:0] PH_RNAME  = 4'd1;
    localparam logic [3:0] PH_SDIGIT = 4'd2;
    localparam logic [3:0] PH_OPT    = 4'd3;
    localparam logic [3:0] PH_OQUOTE = 4'd4;
    localparam logic [3:0] PH_ONAME  = 4'd5;
    localparam logic [3:0] PH_OCOLON = 4'd6;
    localparam logic [3:0] PH_VFIRST = 4'd7;
    localparam logic [3:0] PH_VALUE  = 4'd8;
    localparam logic [3:0] PH_IDLE   = 4'd9;

    logic [3:0]       phase_reg, phase_next;
    logic [3:0]       pos_reg, pos_next;
    logic [4:0]       mask_reg, mask_next;
    logic [15:0]      acc_reg, acc_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [11:0]      vstart_reg, vstart_next;
    logic [11:0]      vcount_reg, vcount_next;
    logic [1:0]       opt_reg, opt_next;

    // Keyword matcher over the resource or option table.
    logic       kw_is_opt;
    logic [4:0] kw_keep, kw_hit;
    logic [2:0] hit_idx;

    always_comb
    begin
        kw_is_opt = (phase_reg == PH_ONAME);
        kw_keep = '0;
        kw_hit = '0;
        hit_idx = '0;
        for (int k = 0; k < NUM_RES; k++)
        begin
            if (mask_reg[k])
            begin
                if (pos_reg < kw_len(kw_is_opt, 3'(k)))
                    kw_keep[k] = (kw_char(kw_is_opt, 3'(k), pos_reg) == header_byte);
                else
                    kw_hit[k] = (pos_reg == kw_len(kw_is_opt, 3'(k)))
                                && (header_byte == CH_QUOTE);
            end
        end
        for (int k = NUM_RES - 1; k >= 0; k--)
        begin
            if (kw_hit[k])
                hit_idx = 3'(k);
        end
    end

    logic        is_close, is_comma, is_quote, is_digit;
    logic [19:0] acc_prod;
    logic [15:0] acc_sat;

    assign is_close = (header_byte == CH_RBRACE);
    assign is_comma = (header_byte == CH_COMMA);
    assign is_quote = (header_byte == CH_QUOTE);
    assign is_digit = (header_byte >= CH_ZERO) && (header_byte <= CH_NINE);
    assign acc_prod = 20'(acc_reg) * 20'd10 + 20'(4'(header_byte - CH_ZERO));
    assign acc_sat  = (acc_prod > 20'd65535) ? 16'hFFFF : acc_prod[15:0];

    logic        prim_v, is_end, is_err, fail, go_value, go_opt;
    logic [2:0]  prim_ev, prim_rid;
    logic [15:0] prim_st;
    logic [1:0]  prim_oid;
    logic [11:0] prim_off, prim_len, val_start, val_cnt;
    res_t        prim_res, term_res;

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        mask_next   = mask_reg;
        acc_next    = acc_reg;
        idx_next    = idx_reg;
        vstart_next = vstart_reg;
        vcount_next = vcount_reg;
        opt_next    = opt_reg;
        prim_v   = 1'b0;
        prim_ev  = EV_RESOURCE;
        prim_rid = '0;
        prim_st  = '0;
        prim_oid = '0;
        prim_off = '0;
        prim_len = '0;
        is_end   = 1'b0;
        is_err   = 1'b0;
        fail     = 1'b0;
        go_value = 1'b0;
        go_opt   = 1'b0;
        val_start = vstart_reg;
        val_cnt   = vcount_reg;

        if (step && phase_reg != PH_IDLE)
        begin
            if (idx_reg >= IDX_LIMIT)
                fail = 1'b1;
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
                case (phase_reg)
                    PH_PREFIX:
                    begin
                        if (pos_reg >= prefix_len(header_mode)
                            || prefix_char(header_mode, pos_reg) != header_byte)
                            fail = 1'b1;
                        else if (pos_reg + 4'd1 == prefix_len(header_mode))
                        begin
                            phase_next = header_mode ? PH_SDIGIT : PH_RNAME;
                            pos_next = '0;
                            mask_next = 5'h1F;
                            acc_next = '0;
                        end
                        else
                            pos_next = pos_reg + 4'd1;
                    end
                    PH_RNAME, PH_ONAME:
                    begin
                        if (kw_hit != '0)
                        begin
                            if (phase_reg == PH_ONAME)
                            begin
                                opt_next = hit_idx[1:0];
                                phase_next = PH_OCOLON;
                            end
                            else if (last_byte)
                                fail = 1'b1;
                            else
                            begin
                                prim_v = 1'b1;
                                prim_ev = EV_RESOURCE;
                                prim_rid = hit_idx;
                                phase_next = PH_OPT;
                            end
                        end
                        else if (kw_keep == '0)
                            fail = 1'b1;
                        else
                        begin
                            mask_next = kw_keep;
                            pos_next = pos_reg + 4'd1;
                        end
                    end
                    PH_SDIGIT:
                    begin
                        if (is_close || is_comma)
                        begin
                            if (acc_reg == '0)
                                fail = 1'b1;
                            else
                            begin
                                prim_v = 1'b1;
                                prim_ev = EV_STATUS;
                                prim_st = acc_reg;
                                phase_next = PH_OPT;
                                go_opt = 1'b1;
                            end
                        end
                        else if (is_digit)
                            acc_next = acc_sat;
                        else
                            fail = 1'b1;
                    end
                    PH_OPT:
                        go_opt = 1'b1;
                    PH_OQUOTE:
                    begin
                        if (is_quote)
                        begin
                            phase_next = PH_ONAME;
                            pos_next = '0;
                            mask_next = 5'h0F;
                        end
                        else
                            fail = 1'b1;
                    end
                    PH_OCOLON:
                    begin
                        if (header_byte == CH_COLON)
                            phase_next = PH_VFIRST;
                        else
                            fail = 1'b1;
                    end
                    PH_VFIRST:
                    begin
                        vcount_next = '0;
                        phase_next = PH_VALUE;
                        if (is_quote)
                            vstart_next = 12'(idx_reg + IDX_W'(1));
                        else
                        begin
                            // An unquoted value starts on this very byte.
                            vstart_next = 12'(idx_reg);
                            val_start = 12'(idx_reg);
                            val_cnt = '0;
                            go_value = 1'b1;
                        end
                    end
                    PH_VALUE:
                        go_value = 1'b1;
                    default:
                        fail = 1'b1;
                endcase

                if (go_value)
                begin
                    if (is_close || is_comma || is_quote)
                    begin
                        prim_v = 1'b1;
                        prim_ev = EV_OPTION;
                        prim_oid = opt_reg;
                        prim_off = val_start;
                        prim_len = val_cnt;
                        phase_next = PH_OPT;
                        // A closing quote is consumed; a brace ends the header and a comma opens the next item.
                        go_opt = !is_quote;
                    end
                    else
                        vcount_next = val_cnt + 12'd1;
                end

                if (go_opt)
                begin
                    if (is_close)
                        is_end = 1'b1;
                    else if (is_comma)
                        phase_next = PH_OQUOTE;
                    else
                        fail = 1'b1;
                end
            end

            is_err = fail || (!is_end && last_byte);
            if ((is_end || is_err) && !last_byte)
                phase_next = PH_IDLE;
        end

        // The last-marked byte always returns the parser to the first line.
        if (step && last_byte && (phase_reg == PH_IDLE || is_end || is_err))
        begin
            phase_next  = PH_PREFIX;
            pos_next    = '0;
            mask_next   = 5'h1F;
            acc_next    = '0;
            idx_next    = '0;
            vstart_next = '0;
            vcount_next = '0;
            opt_next    = '0;
        end
    end

    always_comb
    begin
        prim_res.event_res    = prim_ev;
        prim_res.resource_id  = prim_rid;
        prim_res.status_value = prim_st;
        prim_res.option_id    = prim_oid;
        prim_res.value_offset = prim_off;
        prim_res.value_length = prim_len;
        prim_res.run_last     = !(is_end || is_err);
        term_res = '0;
        term_res.event_res = is_end ? EV_END : EV_ERROR;
        term_res.run_last  = 1'b1;

        push.count  = {1'b0, prim_v} + {1'b0, is_end || is_err};
        push.first  = prim_v ? prim_res : term_res;
        push.second = term_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_PREFIX;
            pos_reg    <= '0;
            mask_reg   <= 5'h1F;
            acc_reg    <= '0;
            idx_reg    <= '0;
            vstart_reg <= '0;
            vcount_reg <= '0;
            opt_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            mask_reg   <= mask_next;
            acc_reg    <= acc_next;
            idx_reg    <= idx_next;
            vstart_reg <= vstart_next;
            vcount_reg <= vcount_next;
            opt_reg    <= opt_next;
        end
    end

    a_two_words_end_in_term: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |->
            (push.second.event_res == EV_END || push.second.event_res == EV_ERROR))
        else $error("second word of a byte is not end or error");

    a_term_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !last_byte && (is_end || is_err)) |=> phase_reg == PH_IDLE)
        else $error("parser did not go idle after end or error");

endmodule

`default_nettype wire

### hdl/phu_result_fifo.sv
// Four-word result queue that takes up to two words per cycle and returns one.
// Depends on phu_pkg.
`default_nettype none

module phu_result_fifo import phu_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  push_t     push,
    input  wire logic pop,
    output logic      head_valid,
    output res_t      head,
    output logic      room_for_two
);

    res_t                  mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;

    assign head_valid   = (cnt_reg != '0);
    assign head         = mem[rd_ptr_reg];
    assign room_for_two = (cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        cnt_next = cnt_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        4'(cnt_reg) + 4'(push.count) <= 4'(FIFO_DEPTH) + 4'(pop))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != '0)
        else $error("result queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

endmodule

`default_nettype wire
